// ----- sv/hsl_to_rgb_converter_defines.svh -----
// assertion macros shared by the hsl to rgb checker
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled while dis is high
`define H2R_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while dis is high
`define H2R_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/h2r_pkg.sv -----
// shared constants and types for the hsl to rgb converter
package h2r_pkg;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned CH_W    = 17;
  localparam int unsigned HM_W    = 15;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned SEC_W   = 3;

  localparam logic [CH_W-1:0]   ONE_Q16       = 17'd65536;
  localparam logic [HUE_W-1:0]  HUE_TURN      = 16'd23040;
  localparam logic [HUE_W-1:0]  HUE_TWO_TURNS = 16'd46080;
  localparam logic [FRAC_W-1:0] HUE_SECTOR    = 12'd3840;

  // rounding offsets and reciprocal of 15 for the divide by 3840 (= 256 * 15)
  localparam logic [CH_W-1:0]   ROUND_Q16     = 17'd32768;
  localparam logic [FRAC_W-1:0] HALF_SECTOR   = 12'd1920;
  localparam logic [20:0]       RECIP_15      = 21'd1118482;
  localparam int unsigned       RECIP_SHIFT   = 24;

  // sector codes, 60 degrees each
  localparam logic [SEC_W-1:0] SEC_RED_YELLOW   = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GREEN_CYAN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYAN_BLUE    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAGENTA_RED  = 3'd5;

  // position of a hue inside the color wheel
  typedef struct packed {
    logic [SEC_W-1:0]  sector;
    logic [FRAC_W-1:0] frac;
  } hue_pos_t;

endpackage

// ----- sv/hsl_to_rgb_converter.sv -----
// hsl to rgb color converter, five-stage pipeline
//
//  channel | payload                              | handshake
//  --------+--------------------------------------+----------------------
//  in      | hue, saturation, lightness, alpha    | in_valid / in_stall
//  out     | red, green, blue, alpha_out          | out_valid / out_stall
//
// one word per cycle sustained while the output is not stalled; an accepted
// word reaches the output register through the stages clamp, chroma multiply,
// second component multiply, divide by 3840 via reciprocal multiply, final mix.
// synchronous reset empties every stage; payload registers are not reset.
// each stage advances when it is empty or the stage after it advances, so a
// stalled output only backs up as far as the first empty stage.
module hsl_to_rgb_converter import h2r_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  hue,
  input  logic [CH_W-1:0]   saturation,
  input  logic [CH_W-1:0]   lightness,
  input  logic [CH_W-1:0]   alpha,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CH_W-1:0]   red,
  output logic [CH_W-1:0]   green,
  output logic [CH_W-1:0]   blue,
  output logic [CH_W-1:0]   alpha_out
);

  // stage valids and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // stage 1: clamp, reduce hue, lightness triangle
  logic [CH_W-1:0] sat_c, lig_c, lig_dist, lig_tri;
  logic [CH_W:0]   twol;
  logic [HM_W-1:0] hm_next;

  assign sat_c    = (saturation > ONE_Q16) ? ONE_Q16 : saturation;
  assign lig_c    = (lightness > ONE_Q16) ? ONE_Q16 : lightness;
  assign twol     = {lig_c, 1'b0};
  assign lig_dist = (twol >= {1'b0, ONE_Q16}) ? CH_W'(twol - {1'b0, ONE_Q16})
                                              : CH_W'({1'b0, ONE_Q16} - twol);
  assign lig_tri  = ONE_Q16 - lig_dist;

  always_comb begin
    priority if (hue >= HUE_TWO_TURNS) begin
      hm_next = HM_W'(hue - HUE_TWO_TURNS);
    end else if (hue >= HUE_TURN) begin
      hm_next = HM_W'(hue - HUE_TURN);
    end else begin
      hm_next = HM_W'(hue);
    end
  end

  logic [HM_W-1:0] s1_hm;
  logic [CH_W-1:0] s1_sat, s1_lig, s1_tri, s1_alpha;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_hm    <= hm_next;
      s1_sat   <= sat_c;
      s1_lig   <= lig_c;
      s1_tri   <= lig_tri;
      s1_alpha <= alpha;
    end
  end

  // stage 2: chroma = round(tri * sat), hue sector split
  logic [2*CH_W-1:0] c_prod;
  logic [2*CH_W:0]   c_round;
  hue_pos_t          pos;

  assign c_prod  = s1_tri * s1_sat;
  assign c_round = {1'b0, c_prod} + (2*CH_W+1)'(ROUND_Q16);

  h2r_hue_split u_split (
    .hm  (s1_hm),
    .pos (pos)
  );

  logic [CH_W-1:0] s2_c, s2_lig, s2_alpha;
  hue_pos_t        s2_pos;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_c     <= c_round[CH_W+15:16];
      s2_lig   <= s1_lig;
      s2_pos   <= pos;
      s2_alpha <= s1_alpha;
    end
  end

  // stage 3: second component numerator and lightness offset
  localparam int unsigned P_W = CH_W + FRAC_W;
  logic [FRAC_W-1:0] fsel;
  logic [P_W-1:0]    x_num;

  assign fsel  = s2_pos.sector[0] ? (HUE_SECTOR - s2_pos.frac) : s2_pos.frac;
  assign x_num = s2_c * fsel;

  logic [P_W-1:0]   s3_num;
  logic [CH_W-1:0]  s3_c, s3_m, s3_alpha;
  logic [SEC_W-1:0] s3_sec;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_num   <= x_num;
      s3_c     <= s2_c;
      s3_m     <= s2_lig - {1'b0, s2_c[CH_W-1:1]};
      s3_sec   <= s2_pos.sector;
      s3_alpha <= s2_alpha;
    end
  end

  // stage 4: divide by 3840 as shift by 8 then multiply by reciprocal of 15
  localparam int unsigned N_W = P_W - 7;
  localparam int unsigned Q_W = N_W + 21;
  logic [P_W:0]   x_rnd;
  logic [N_W-1:0] x_n;
  logic [Q_W-1:0] x_q;

  assign x_rnd = {1'b0, s3_num} + (P_W+1)'(HALF_SECTOR);
  assign x_n   = x_rnd[P_W:8];
  assign x_q   = x_n * RECIP_15;

  logic [Q_W-1:0]   s4_q;
  logic [CH_W-1:0]  s4_c, s4_m, s4_alpha;
  logic [SEC_W-1:0] s4_sec;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_q     <= x_q;
      s4_c     <= s3_c;
      s4_m     <= s3_m;
      s4_sec   <= s3_sec;
      s4_alpha <= s3_alpha;
    end
  end

  // stage 5: place chroma and second component, add offset
  logic [CH_W-1:0] x_val, r_raw, g_raw, b_raw;

  assign x_val = s4_q[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

  always_comb begin
    r_raw = '0;
    g_raw = '0;
    b_raw = '0;
    unique case (s4_sec)
      SEC_RED_YELLOW: begin
        r_raw = s4_c;
        g_raw = x_val;
      end
      SEC_YELLOW_GREEN: begin
        r_raw = x_val;
        g_raw = s4_c;
      end
      SEC_GREEN_CYAN: begin
        g_raw = s4_c;
        b_raw = x_val;
      end
      SEC_CYAN_BLUE: begin
        g_raw = x_val;
        b_raw = s4_c;
      end
      SEC_BLUE_MAGENTA: begin
        r_raw = x_val;
        b_raw = s4_c;
      end
      default: begin
        r_raw = s4_c;
        b_raw = x_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      red       <= r_raw + s4_m;
      green     <= g_raw + s4_m;
      blue      <= b_raw + s4_m;
      alpha_out <= s4_alpha;
    end
  end

endmodule

// ----- sv/h2r_hue_split.sv -----
// splits a reduced hue into its 60 degree sector and the offset within it
module h2r_hue_split import h2r_pkg::*; (
  input  logic [HM_W-1:0] hm,
  output hue_pos_t        pos
);

  logic [HM_W-1:0] s1, s2, s3, s4, s5;

  // sector boundaries at multiples of 3840
  assign s1 = HM_W'(1 * HUE_SECTOR);
  assign s2 = HM_W'(2 * HUE_SECTOR);
  assign s3 = HM_W'(3 * HUE_SECTOR);
  assign s4 = HM_W'(4 * HUE_SECTOR);
  assign s5 = HM_W'(5 * HUE_SECTOR);

  // compare against all boundaries, highest first
  always_comb begin
    priority if (hm >= s5) begin
      pos.sector = SEC_MAGENTA_RED;
      pos.frac   = FRAC_W'(hm - s5);
    end else if (hm >= s4) begin
      pos.sector = SEC_BLUE_MAGENTA;
      pos.frac   = FRAC_W'(hm - s4);
    end else if (hm >= s3) begin
      pos.sector = SEC_CYAN_BLUE;
      pos.frac   = FRAC_W'(hm - s3);
    end else if (hm >= s2) begin
      pos.sector = SEC_GREEN_CYAN;
      pos.frac   = FRAC_W'(hm - s2);
    end else if (hm >= s1) begin
      pos.sector = SEC_YELLOW_GREEN;
      pos.frac   = FRAC_W'(hm - s1);
    end else begin
      pos.sector = SEC_RED_YELLOW;
      pos.frac   = FRAC_W'(hm);
    end
  end

endmodule

// ----- sv/h2r_checker.sv -----
// port-level checks for the hsl to rgb converter, bound to the top level
`include "hsl_to_rgb_converter_defines.svh"

module h2r_checker import h2r_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [HUE_W-1:0]  hue,
  input logic [CH_W-1:0]   saturation,
  input logic [CH_W-1:0]   lightness,
  input logic [CH_W-1:0]   alpha,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CH_W-1:0]   red,
  input logic [CH_W-1:0]   green,
  input logic [CH_W-1:0]   blue,
  input logic [CH_W-1:0]   alpha_out
);

  // a stalled output word stays put
  `H2R_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha_out), "stalled output word changed")

  // reset leaves the pipeline empty
  `H2R_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "output valid right after reset")

  // a free-running output never backs up the input
  `H2R_ASSERT_NOW(a_no_false_stall, clk, rst, !out_stall || !out_valid, !in_stall, "input stalled while output drains")

  // color components never exceed one
  `H2R_ASSERT_NOW(a_range, clk, rst, out_valid, red <= ONE_Q16 && green <= ONE_Q16 && blue <= ONE_Q16, "color component above one")

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (.*);
